@@ sv/sm3_pkg.sv @@
// Shared types, constants and helper functions of the SM3 hash engine.
package sm3_pkg;

    typedef logic [31:0] word_t;

    // Word source for a push into the block window
    typedef logic [2:0] word_sel_t;
    localparam word_sel_t SEL_DATA   = 3'd0;
    localparam word_sel_t SEL_LAST   = 3'd1;
    localparam word_sel_t SEL_MARK   = 3'd2;
    localparam word_sel_t SEL_ZERO   = 3'd3;
    localparam word_sel_t SEL_LEN_HI = 3'd4;
    localparam word_sel_t SEL_LEN_LO = 3'd5;

    localparam word_t T_LOW    = 32'h79CC4519;
    localparam word_t T_HIGH   = 32'h7A879D8A;
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam word_t MARK_WORD = {PAD_MARK, 24'h000000};

    localparam int ROUNDS = 64;

    localparam word_t IV [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      push;
        word_sel_t sel;
        logic      len_add;
        logic      len_last;
        logic      load_work;
        logic      round_en;
        logic [5:0] round;
        logic      fold;
        logic      out_load;
        logic [2:0] out_idx;
        logic      restart;
    } cmd_t;

    function automatic word_t rotl32(input word_t x, input logic [4:0] n);
        logic [63:0] tmp;
        tmp = {x, x} << n;
        return tmp[63:32];
    endfunction

    function automatic word_t perm0(input word_t x);
        return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic word_t perm1(input word_t x);
        return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

    // Round constant, rotated by the round number mod 32
    function automatic word_t round_const(input logic [5:0] j);
        word_t t;
        t = (j < 6'd16) ? T_LOW : T_HIGH;
        return rotl32(t, j[4:0]);
    endfunction

    // Keep the valid leading bytes of a short final word and append the marker
    function automatic word_t pad_word(input word_t data, input logic [2:0] n);
        word_t w;
        case (n)
            3'd0:    w = MARK_WORD;
            3'd1:    w = {data[31:24], PAD_MARK, 16'h0000};
            3'd2:    w = {data[31:16], PAD_MARK, 8'h00};
            3'd3:    w = {data[31:8], PAD_MARK};
            default: w = data;
        endcase
        return w;
    endfunction

endpackage

@@ sv/sm3_ctrl.sv @@
// Controller of the SM3 hash engine: word counting, padding sequence, rounds, digest.
module sm3_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          data_valid,
    output logic          data_ready,
    input  logic [2:0]    valid_bytes,
    input  logic          last_word,
    output logic          digest_valid,
    input  logic          digest_ready,
    output sm3_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_COMP = 3'd2;
    localparam logic [2:0] S_FOLD = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [3:0] count_reg, count_next;
    logic [5:0] round_reg, round_next;
    logic [2:0] idx_reg, idx_next;
    logic       mark_reg, mark_next;
    logic       len_reg, len_next;
    logic       pad_reg, pad_next;
    logic       final_reg, final_next;
    logic       dv_reg, dv_next;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        mark_next  = mark_reg;
        len_next   = len_reg;
        pad_next   = pad_reg;
        final_next = final_reg;
        cmd          = '0;
        cmd.sel      = sm3_pkg::SEL_ZERO;
        cmd.round    = round_reg;
        cmd.out_idx  = idx_reg;
        data_ready   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                data_ready = 1'b1;
                if (data_valid)
                begin
                    cmd.push    = 1'b1;
                    cmd.len_add = 1'b1;
                    cmd.sel     = sm3_pkg::SEL_DATA;
                    if (last_word)
                    begin
                        cmd.len_last = 1'b1;
                        pad_next     = 1'b1;
                        if (valid_bytes >= 3'd4)
                            mark_next = 1'b1;
                        else
                            cmd.sel = sm3_pkg::SEL_LAST;
                        state_next = S_FILL;
                    end
                end
            end
            S_FILL:
            begin
                cmd.push = 1'b1;
                if (mark_reg)
                begin
                    cmd.sel   = sm3_pkg::SEL_MARK;
                    mark_next = 1'b0;
                end
                else if (len_reg)
                begin
                    cmd.sel    = sm3_pkg::SEL_LEN_LO;
                    final_next = 1'b1;
                end
                else if (count_reg == 4'd14)
                begin
                    cmd.sel  = sm3_pkg::SEL_LEN_HI;
                    len_next = 1'b1;
                end
                else
                    cmd.sel = sm3_pkg::SEL_ZERO;
            end
            S_COMP:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == 6'(sm3_pkg::ROUNDS - 1))
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold = 1'b1;
                if (final_reg)
                begin
                    state_next = S_OUT;
                    final_next = 1'b0;
                    pad_next   = 1'b0;
                    len_next   = 1'b0;
                end
                else if (pad_reg)
                    state_next = S_FILL;
                else
                    state_next = S_IDLE;
            end
            S_OUT:
            begin
                if (!dv_reg || digest_ready)
                begin
                    cmd.out_load = 1'b1;
                    idx_next     = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Count the pushed word; a full block starts the rounds
        if (cmd.push)
        begin
            count_next = count_reg + 4'd1;
            if (count_reg == 4'd15)
            begin
                cmd.load_work = 1'b1;
                round_next    = '0;
                state_next    = S_COMP;
            end
        end

        dv_next = cmd.out_load ? 1'b1 : (digest_ready ? 1'b0 : dv_reg);
    end

    assign digest_valid = dv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
            mark_reg  <= 1'b0;
            len_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            final_reg <= 1'b0;
            dv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            mark_reg  <= mark_next;
            len_reg   <= len_next;
            pad_reg   <= pad_next;
            final_reg <= final_next;
            dv_reg    <= dv_next;
        end
    end

endmodule

@@ sv/sm3_dp.sv @@
// Datapath of the SM3 hash engine: block window, round logic, chaining value, length.
module sm3_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sm3_pkg::cmd_t        cmd,
    input  logic [31:0]          data_word,
    input  logic [2:0]           valid_bytes,
    output logic [31:0]          digest_word,
    output logic [2:0]           digest_index,
    output logic                 digest_last
);

    sm3_pkg::word_t win_reg [16];
    sm3_pkg::word_t work_reg [8];
    sm3_pkg::word_t cv_reg [8];
    logic [63:0]    len_reg;
    logic [31:0]    dword_reg;
    logic [2:0]     didx_reg;
    logic           dlast_reg;

    logic [2:0]     n_clip;
    logic [5:0]     len_inc;
    sm3_pkg::word_t push_word;
    sm3_pkg::word_t new_word;
    sm3_pkg::word_t tc, a12, ss1, ss2, ff, gg, tt1, tt2, w0, w4;

    // Clip the byte count and select the word to push
    always_comb
    begin
        n_clip  = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
        len_inc = cmd.len_last ? {n_clip, 3'b000} : 6'd32;
        case (cmd.sel)
            sm3_pkg::SEL_DATA:   push_word = data_word;
            sm3_pkg::SEL_LAST:   push_word = sm3_pkg::pad_word(data_word, n_clip);
            sm3_pkg::SEL_MARK:   push_word = sm3_pkg::MARK_WORD;
            sm3_pkg::SEL_LEN_HI: push_word = len_reg[63:32];
            sm3_pkg::SEL_LEN_LO: push_word = len_reg[31:0];
            default:             push_word = '0;
        endcase
    end

    // Expand the next message word and compute one round
    always_comb
    begin
        w0  = win_reg[0];
        w4  = win_reg[4];
        new_word = sm3_pkg::perm1(win_reg[0] ^ win_reg[7] ^ sm3_pkg::rotl32(win_reg[13], 5'd15))
                   ^ sm3_pkg::rotl32(win_reg[3], 5'd7) ^ win_reg[10];
        tc  = sm3_pkg::round_const(cmd.round);
        a12 = sm3_pkg::rotl32(work_reg[0], 5'd12);
        ss1 = sm3_pkg::rotl32(a12 + work_reg[4] + tc, 5'd7);
        ss2 = ss1 ^ a12;
        if (cmd.round < 6'd16)
        begin
            ff = work_reg[0] ^ work_reg[1] ^ work_reg[2];
            gg = work_reg[4] ^ work_reg[5] ^ work_reg[6];
        end
        else
        begin
            ff = (work_reg[0] & work_reg[1]) | (work_reg[0] & work_reg[2])
                 | (work_reg[1] & work_reg[2]);
            gg = (work_reg[4] & work_reg[5]) | (~work_reg[4] & work_reg[6]);
        end
        tt1 = ff + work_reg[3] + ss2 + (w0 ^ w4);
        tt2 = gg + work_reg[7] + ss1 + w0;
    end

    // Shift the window on a push or a round
    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[15] <= cmd.push ? push_word : new_word;
        end
    end

    // Load the working variables or advance one round
    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            for (int i = 0; i < 8; i++)
                work_reg[i] <= cv_reg[i];
        end
        else if (cmd.round_en)
        begin
            work_reg[0] <= tt1;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= sm3_pkg::rotl32(work_reg[1], 5'd9);
            work_reg[3] <= work_reg[2];
            work_reg[4] <= sm3_pkg::perm0(tt2);
            work_reg[5] <= work_reg[4];
            work_reg[6] <= sm3_pkg::rotl32(work_reg[5], 5'd19);
            work_reg[7] <= work_reg[6];
        end
    end

    // Fold the block into the chaining value; restart from the IV after a digest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                cv_reg[i] <= sm3_pkg::IV[i];
            len_reg <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                for (int i = 0; i < 8; i++)
                    cv_reg[i] <= sm3_pkg::IV[i];
            end
            else if (cmd.fold)
            begin
                for (int i = 0; i < 8; i++)
                    cv_reg[i] <= cv_reg[i] ^ work_reg[i];
            end
            if (cmd.restart)
                len_reg <= '0;
            else if (cmd.len_add)
                len_reg <= len_reg + {58'd0, len_inc};
        end
    end

    // Hold the outgoing digest word
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            dword_reg <= cv_reg[cmd.out_idx];
            didx_reg  <= cmd.out_idx;
            dlast_reg <= (cmd.out_idx == 3'd7);
        end
    end

    assign digest_word  = dword_reg;
    assign digest_index = didx_reg;
    assign digest_last  = dlast_reg;

endmodule

@@ sv/sm3_hash_engine.sv @@
// Top level of the SM3 hash engine: controller and datapath.
//
//  channel   direction  handshake                   word contents
//  data      in         data_valid / data_ready     data_word, valid_bytes, last_word
//  digest    out        digest_valid / digest_ready digest_word, digest_index, digest_last
//
// A message word is taken while data_ready is high; the sixteenth word of a block starts the
// 64-round compression, one round per cycle, followed by a fold of the result into the
// chaining value; the round loop sets the rate, as no new word is taken until the fold is done.
// The final word adds the padding words and one or two compressions, then eight digest
// words leave one per cycle while digest_ready is high.
// data_ready is low during padding, compression and digest output; a held digest
// word does not stop the next message from entering. Reset is immediate, no sweep.
module sm3_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_word,
    output logic        digest_valid,
    input  logic        digest_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  digest_index,
    output logic        digest_last
);

    sm3_pkg::cmd_t cmd;

    sm3_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .valid_bytes  (valid_bytes),
        .last_word    (last_word),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .cmd          (cmd)
    );

    sm3_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .data_word    (data_word),
        .valid_bytes  (valid_bytes),
        .digest_word  (digest_word),
        .digest_index (digest_index),
        .digest_last  (digest_last)
    );

    // A full block starts at round zero
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_work |=> cmd.round_en && cmd.round == 6'd0)
        else $error("compression did not start at round zero");

    // The fold follows the last round
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fold |-> $past(cmd.round_en) && $past(cmd.round) == 6'd63)
        else $error("fold without a completed round loop");

    // The eighth digest word returns the engine to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && cmd.out_idx == 3'd7 |=> data_ready && digest_last && digest_valid)
        else $error("engine not idle after the last digest word");

endmodule
